>>> design/barrier_crossing_controller_unit_defines.svh
// Assertion macros for the barrier crossing controller.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef BARRIER_CROSSING_CONTROLLER_UNIT_DEFINES_SVH
`define BARRIER_CROSSING_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define BCC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bcc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define BCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bcc: next-cycle check failed");

`endif

>>> design/bcc_pkg.sv
// Shared constants for the barrier crossing controller.
// No dependencies; used by the top level and the drive calculator.
package bcc_pkg;

    localparam int DRIVE_W   = 8;
    localparam int HEADING_W = 13;
    localparam int GAIN_W    = 10;

    // One full turn and half a turn, in 1/16 degree
    localparam int FULL_TURN = 5760;
    localparam int HALF_TURN = 2880;
    localparam int DRIVE_MAX = 127;

    localparam int PAUSE_TICKS_DEFAULT = 20;

    localparam logic [1:0] BRAKE_NONE = 2'd0;
    localparam logic [1:0] BRAKE_STOP = 2'd1;
    localparam logic [1:0] BRAKE_HOLD = 2'd2;

    localparam logic [2:0] CFG_CROSSING_COUNT  = 3'd0;
    localparam logic [2:0] CFG_REVERSE_DIR     = 3'd1;
    localparam logic [2:0] CFG_FULL_DROP       = 3'd2;
    localparam logic [2:0] CFG_CLIMB_THRESHOLD = 3'd3;
    localparam logic [2:0] CFG_LEVEL_THRESHOLD = 3'd4;
    localparam logic [2:0] CFG_TIMEOUT_TICKS   = 3'd5;
    localparam logic [2:0] CFG_HEADING_GAIN    = 3'd6;
    localparam logic [2:0] CFG_LANDING_TICKS   = 3'd7;

endpackage

>>> design/bcc_drive.sv
// Heading-hold tank drive calculator: wrapped heading error times gain,
// added to full speed and saturated. Depends on bcc_pkg.
module bcc_drive import bcc_pkg::*; (
    input  logic [HEADING_W-1:0]      i_target,
    input  logic [HEADING_W-1:0]      i_heading,
    input  logic [GAIN_W-1:0]         i_gain,
    input  logic                      i_reverse,
    output logic signed [DRIVE_W-1:0] o_left,
    output logic signed [DRIVE_W-1:0] o_right
);

    logic signed [14:0] diff;
    logic signed [12:0] err;
    logic signed [23:0] prod;
    logic signed [23:0] prod_adj;
    logic signed [15:0] offset;
    logic signed [16:0] base;
    logic signed [16:0] sum_l;
    logic signed [16:0] sum_r;

    function automatic logic signed [DRIVE_W-1:0] sat_drive(input logic signed [16:0] v);
        if (v > 17'sd127)
            return DRIVE_W'(DRIVE_MAX);
        else if (v < -17'sd127)
            return DRIVE_W'(-DRIVE_MAX);
        else
            return DRIVE_W'(v);
    endfunction

    always_comb begin
        diff = $signed({2'b00, i_target}) - $signed({2'b00, i_heading});
        // one step of wrap covers every 13-bit difference
        if (diff > 15'(HALF_TURN))
            err = 13'(diff - 15'(FULL_TURN));
        else if (diff < -15'(HALF_TURN))
            err = 13'(diff + 15'(FULL_TURN));
        else
            err = 13'(diff);
        prod = 24'(err) * $signed({14'd0, i_gain});
        // truncate towards zero on the divide by 256
        prod_adj = (prod < 0) ? prod + 24'sd255 : prod;
        offset = 16'(prod_adj >>> 8);
        base   = i_reverse ? -17'(DRIVE_MAX) : 17'(DRIVE_MAX);
        sum_l  = base + 17'(offset);
        sum_r  = base - 17'(offset);
        o_left  = sat_drive(sum_l);
        o_right = sat_drive(sum_r);
    end

endmodule

>>> design/barrier_crossing_controller_unit.sv
// Barrier crossing controller: takes one item per clock cycle while not stalled, start or
// sensor tick, and returns one result item per input through the input register, then the
// result register. The path between them is the heading error multiply
// (13 x 11 bits) plus the crossing sequencer, so the sustained rate is one item per
// cycle while the output side keeps up. Configuration writes are taken in any cycle
// and apply to items processed after them.
module barrier_crossing_controller_unit import bcc_pkg::*; #(
    parameter int PAUSE_TICKS = PAUSE_TICKS_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_action,
    input  logic signed [12:0]        i_roll_angle,
    input  logic [HEADING_W-1:0]      i_heading_angle,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [DRIVE_W-1:0] o_left_drive,
    output logic signed [DRIVE_W-1:0] o_right_drive,
    output logic [1:0]                o_brake_mode,
    output logic [2:0]                o_phase,
    output logic [3:0]                o_crossing_index,
    output logic                      o_finished,
    input  logic                      i_cfg_we,
    input  logic [2:0]                i_cfg_index,
    input  logic [15:0]               i_cfg_wdata
);

    `include "barrier_crossing_controller_unit_defines.svh"

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_CROSS   = 3'd1,
        PH_LAND    = 3'd2,
        PH_PAUSE   = 3'd3,
        PH_DONE    = 3'd4,
        PH_TIMEOUT = 3'd5
    } t_phase;

    localparam logic [15:0] PAUSE_LIMIT = 16'(PAUSE_TICKS);

    // configuration
    logic [3:0]        r_cfg_count;
    logic              r_cfg_reverse;
    logic              r_cfg_full_drop;
    logic [11:0]       r_cfg_climb;
    logic [11:0]       r_cfg_level;
    logic [15:0]       r_cfg_timeout;
    logic [GAIN_W-1:0] r_cfg_gain;
    logic [15:0]       r_cfg_landing;

    // input register
    logic                 r_in_valid;
    logic                 r_in_action;
    logic signed [12:0]   r_in_roll;
    logic [HEADING_W-1:0] r_in_heading;

    // controller state
    t_phase               r_phase, n_phase;
    logic                 r_climbed, n_climbed;
    logic                 r_dropped, n_dropped;
    logic [HEADING_W-1:0] r_target, n_target;
    logic [15:0]          r_ticks, n_ticks;
    logic [3:0]           r_done, n_done;
    logic [1:0]           r_stop_mode, n_stop_mode;

    // result register
    logic                      r_out_valid;
    logic signed [DRIVE_W-1:0] r_left, n_left;
    logic signed [DRIVE_W-1:0] r_right, n_right;
    logic [1:0]                r_brake, n_brake;
    logic                      r_fin, n_fin;

    logic                      adv;
    logic signed [DRIVE_W-1:0] drv_left;
    logic signed [DRIVE_W-1:0] drv_right;
    logic signed [13:0]        roll_x;
    logic signed [13:0]        pitch;
    logic signed [13:0]        lvl;
    logic signed [13:0]        climb;

    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;

    bcc_drive u_drive (
        .i_target  (r_target),
        .i_heading (r_in_heading),
        .i_gain    (r_cfg_gain),
        .i_reverse (r_cfg_reverse),
        .o_left    (drv_left),
        .o_right   (drv_right)
    );

    assign roll_x = 14'(r_in_roll);
    assign pitch  = r_cfg_reverse ? -roll_x : roll_x;
    assign lvl    = $signed({2'b00, r_cfg_level});
    assign climb  = $signed({2'b00, r_cfg_climb});

    always_comb begin
        logic              run;
        logic              ended;
        logic [1:0]        end_mode;
        logic [15:0]       t;
        logic              c;
        logic              d;

        n_phase     = r_phase;
        n_target    = r_target;
        n_done      = r_done;
        n_stop_mode = r_stop_mode;
        n_left      = '0;
        n_right     = '0;
        n_brake     = BRAKE_NONE;
        n_fin       = 1'b0;
        t           = r_ticks;
        c           = r_climbed;
        d           = r_dropped;
        run         = 1'b0;
        ended       = 1'b0;
        end_mode    = BRAKE_NONE;

        if (!r_in_action) begin
            // start: latch heading and restart the run
            n_target    = r_in_heading;
            n_done      = '0;
            c           = 1'b0;
            d           = 1'b0;
            t           = '0;
            n_stop_mode = BRAKE_NONE;
            if (r_cfg_count == '0) begin
                n_phase = PH_DONE;
                n_fin   = 1'b1;
            end else begin
                n_phase = PH_CROSS;
            end
        end else begin
            unique case (r_phase)
                PH_LAND: begin
                    if (r_ticks >= r_cfg_landing) begin
                        n_brake  = BRAKE_STOP;
                        ended    = 1'b1;
                        end_mode = BRAKE_STOP;
                    end else begin
                        n_left  = drv_left;
                        n_right = drv_right;
                        t       = r_ticks + 16'd1;
                    end
                end
                PH_PAUSE, PH_CROSS: begin
                    run = 1'b1;
                    if (r_phase == PH_PAUSE) begin
                        if (t != 16'hFFFF)
                            t = t + 16'd1;
                        if (t >= PAUSE_LIMIT) begin
                            n_phase = PH_CROSS;
                            c       = 1'b0;
                            d       = 1'b0;
                            t       = '0;
                        end else begin
                            n_brake = r_stop_mode;
                            run     = 1'b0;
                        end
                    end
                    if (run) begin
                        if (t > r_cfg_timeout) begin
                            n_brake     = BRAKE_STOP;
                            n_stop_mode = BRAKE_STOP;
                            n_phase     = PH_TIMEOUT;
                            n_fin       = 1'b1;
                        end else begin
                            if (t != 16'hFFFF)
                                t = t + 16'd1;
                            n_left  = drv_left;
                            n_right = drv_right;
                            if (pitch > climb)
                                c = 1'b1;
                            if (c && pitch < lvl)
                                d = 1'b1;
                            if (c && d) begin
                                if (r_cfg_full_drop && pitch < lvl && pitch > -lvl) begin
                                    if (r_cfg_landing == '0) begin
                                        n_left   = '0;
                                        n_right  = '0;
                                        n_brake  = BRAKE_STOP;
                                        ended    = 1'b1;
                                        end_mode = BRAKE_STOP;
                                    end else begin
                                        n_phase = PH_LAND;
                                        t       = 16'd1;
                                    end
                                end else if (!r_cfg_full_drop && pitch < -lvl) begin
                                    n_left   = '0;
                                    n_right  = '0;
                                    n_brake  = BRAKE_HOLD;
                                    ended    = 1'b1;
                                    end_mode = BRAKE_HOLD;
                                end
                            end
                        end
                    end
                end
                default: begin
                    n_brake = r_stop_mode;
                end
            endcase
        end

        // close the crossing: count it, then pause or finish the run
        if (ended) begin
            n_stop_mode = end_mode;
            n_done      = r_done + 4'd1;
            t           = '0;
            if (n_done >= r_cfg_count) begin
                n_phase = PH_DONE;
                n_fin   = 1'b1;
            end else begin
                n_phase = PH_PAUSE;
            end
        end

        n_ticks   = t;
        n_climbed = c;
        n_dropped = d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count     <= 4'd2;
            r_cfg_reverse   <= 1'b0;
            r_cfg_full_drop <= 1'b1;
            r_cfg_climb     <= 12'd144;
            r_cfg_level     <= 12'd8;
            r_cfg_timeout   <= 16'd300;
            r_cfg_gain      <= GAIN_W'(112);
            r_cfg_landing   <= 16'd20;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CROSSING_COUNT:  r_cfg_count     <= i_cfg_wdata[3:0];
                CFG_REVERSE_DIR:     r_cfg_reverse   <= i_cfg_wdata[0];
                CFG_FULL_DROP:       r_cfg_full_drop <= i_cfg_wdata[0];
                CFG_CLIMB_THRESHOLD: r_cfg_climb     <= i_cfg_wdata[11:0];
                CFG_LEVEL_THRESHOLD: r_cfg_level     <= i_cfg_wdata[11:0];
                CFG_TIMEOUT_TICKS:   r_cfg_timeout   <= i_cfg_wdata;
                CFG_HEADING_GAIN:    r_cfg_gain      <= i_cfg_wdata[GAIN_W-1:0];
                CFG_LANDING_TICKS:   r_cfg_landing   <= i_cfg_wdata;
                default:             r_cfg_landing   <= r_cfg_landing;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_climbed   <= 1'b0;
            r_dropped   <= 1'b0;
            r_target    <= '0;
            r_ticks     <= '0;
            r_done      <= '0;
            r_stop_mode <= BRAKE_NONE;
            r_left      <= '0;
            r_right     <= '0;
            r_brake     <= BRAKE_NONE;
            r_fin       <= 1'b0;
        end else begin
            if (!o_in_stall)
                r_in_valid <= i_in_valid;
            if (adv) begin
                r_out_valid <= 1'b1;
                r_phase     <= n_phase;
                r_climbed   <= n_climbed;
                r_dropped   <= n_dropped;
                r_target    <= n_target;
                r_ticks     <= n_ticks;
                r_done      <= n_done;
                r_stop_mode <= n_stop_mode;
                r_left      <= n_left;
                r_right     <= n_right;
                r_brake     <= n_brake;
                r_fin       <= n_fin;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers: hold while stalled
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_action  <= i_action;
            r_in_roll    <= i_roll_angle;
            r_in_heading <= i_heading_angle;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_left_drive     = r_left;
    assign o_right_drive    = r_right;
    assign o_brake_mode     = r_brake;
    assign o_phase          = r_phase;
    assign o_crossing_index = r_done;
    assign o_finished       = r_fin;

    `BCC_ASSERT_IMPLY(a_fin_phase, i_clk, i_rst_n, o_out_valid && o_finished, o_phase == PH_DONE || o_phase == PH_TIMEOUT)
    `BCC_ASSERT_IMPLY(a_brake_zero, i_clk, i_rst_n, o_out_valid && o_brake_mode != BRAKE_NONE, o_left_drive == 0 && o_right_drive == 0)
    `BCC_ASSERT_IMPLY(a_land_free, i_clk, i_rst_n, o_out_valid && o_phase == PH_LAND, o_brake_mode == BRAKE_NONE)
    `BCC_ASSERT_NEXT(a_adv_out, i_clk, i_rst_n, adv, r_out_valid)

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for barrier_crossing_controller_unit: a directed table, then
// random crossing sequences, checked against fixed expected results or a cycle-free predictor of the sequencer.
// Depends on bcc_pkg and the unit itself; reads no files.
module testbench;
    import bcc_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 100;
    localparam int PHASE_ITEMS = 115;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE, PH_CROSSING, PH_LANDING, PH_PAUSE, PH_DONE, PH_TIMED_OUT
    } t_run_phase;

    typedef struct packed {
        logic signed [7:0] left_drv;
        logic signed [7:0] right_drv;
        logic [1:0]        brake;
        logic [2:0]        phase;
        logic [3:0]        index;
        logic              finished;
    } t_crossing_result;

    typedef struct packed {
        logic [3:0]  crossings;
        logic        reverse_dir;
        logic        full_drop;
        logic [11:0] climb_thr;
        logic [11:0] level_thr;
        logic [15:0] timeout;
        logic [9:0]  gain;
        logic [15:0] landing;
    } t_crossing_cfg;

    typedef struct packed {
        logic [3:0]        setup;
        logic              act;
        logic signed [12:0] roll;
        logic [12:0]       hdg;
        logic              fixed_exp;
        t_crossing_result  want;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic i_action = 1'b0;
    logic signed [12:0] i_roll_angle = '0;
    logic [HEADING_W-1:0] i_heading_angle = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [DRIVE_W-1:0] o_left_drive;
    logic signed [DRIVE_W-1:0] o_right_drive;
    logic [1:0] o_brake_mode;
    logic [2:0] o_phase;
    logic [3:0] o_crossing_index;
    logic o_finished;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_index = '0;
    logic [15:0] i_cfg_wdata = '0;

    barrier_crossing_controller_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_roll_angle     (i_roll_angle),
        .i_heading_angle  (i_heading_angle),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_left_drive     (o_left_drive),
        .o_right_drive    (o_right_drive),
        .o_brake_mode     (o_brake_mode),
        .o_phase          (o_phase),
        .o_crossing_index (o_crossing_index),
        .o_finished       (o_finished),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state and the register copy it runs on
    t_crossing_cfg cfg;
    t_run_phase    ph;
    logic          climbed, dropped;
    logic [12:0]   tgt_heading;
    logic [15:0]   ticks;
    logic [3:0]    done_cnt;
    logic [1:0]    last_stop;

    t_crossing_result results_due[$];
    t_stim_row        directed_rows[$];
    t_crossing_cfg    settings[9];

    int error_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    int runs_ended = 0;
    int timeouts_seen = 0;
    int send_idle_pct = 15;
    int recv_idle_pct = 45;
    int idle_cycles = 0;
    t_crossing_result monitor_want;

    task automatic report_error(string msg);
        if (error_count < MAX_REPORTS)
            $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic logic signed [7:0] clip127(int v);
        if (v > DRIVE_MAX) return 8'sd127;
        if (v < -DRIVE_MAX) return -8'sd127;
        return v[7:0];
    endfunction

    // {left, right} for the current heading error
    function automatic logic [15:0] drive_pair(logic [12:0] hdg);
        int err, base, off;
        err = int'(tgt_heading) - int'(hdg);
        base = cfg.reverse_dir ? -DRIVE_MAX : DRIVE_MAX;
        while (err > HALF_TURN) err -= FULL_TURN;
        while (err < -HALF_TURN) err += FULL_TURN;
        off = (err * int'(cfg.gain)) / 256;
        return {clip127(base + off), clip127(base - off)};
    endfunction

    function automatic logic finish_crossing(logic [1:0] mode);
        last_stop = mode;
        done_cnt = done_cnt + 4'd1;
        ticks = '0;
        if (done_cnt >= cfg.crossings) begin
            ph = PH_DONE;
            return 1'b1;
        end
        ph = PH_PAUSE;
        return 1'b0;
    endfunction

    function automatic t_crossing_result crossing_step(logic act, logic signed [12:0] roll,
                                                       logic [12:0] hdg);
        t_crossing_result r;
        int pitch, lvl;
        logic advance;
        r = '0;
        pitch = roll;
        if (cfg.reverse_dir) pitch = -pitch;
        lvl = int'(cfg.level_thr);
        if (act == ACT_START) begin
            tgt_heading = hdg;
            done_cnt = '0;
            climbed = 1'b0;
            dropped = 1'b0;
            ticks = '0;
            last_stop = BRAKE_NONE;
            if (cfg.crossings == 4'd0) begin
                ph = PH_DONE;
                r.finished = 1'b1;
            end else begin
                ph = PH_CROSSING;
            end
        end else if (ph == PH_LANDING) begin
            if (ticks >= cfg.landing) begin
                r.brake = BRAKE_STOP;
                r.finished = finish_crossing(BRAKE_STOP);
            end else begin
                {r.left_drv, r.right_drv} = drive_pair(hdg);
                ticks = ticks + 16'd1;
            end
        end else if (ph == PH_PAUSE || ph == PH_CROSSING) begin
            advance = 1'b1;
            if (ph == PH_PAUSE) begin
                if (ticks != 16'hFFFF) ticks = ticks + 16'd1;
                if (ticks >= PAUSE_TICKS_DEFAULT) begin
                    ph = PH_CROSSING;
                    climbed = 1'b0;
                    dropped = 1'b0;
                    ticks = '0;
                end else begin
                    r.brake = last_stop;
                    advance = 1'b0;
                end
            end
            if (advance) begin
                if (ticks > cfg.timeout) begin
                    r.brake = BRAKE_STOP;
                    last_stop = BRAKE_STOP;
                    ph = PH_TIMED_OUT;
                    r.finished = 1'b1;
                end else begin
                    if (ticks != 16'hFFFF) ticks = ticks + 16'd1;
                    {r.left_drv, r.right_drv} = drive_pair(hdg);
                    if (!climbed && pitch > int'(cfg.climb_thr)) climbed = 1'b1;
                    if (climbed && !dropped && pitch < lvl) dropped = 1'b1;
                    if (climbed && dropped) begin
                        if (cfg.full_drop && pitch < lvl && pitch > -lvl) begin
                            if (cfg.landing == 16'd0) begin
                                r.left_drv = '0;
                                r.right_drv = '0;
                                r.brake = BRAKE_STOP;
                                r.finished = finish_crossing(BRAKE_STOP);
                            end else begin
                                ph = PH_LANDING;
                                ticks = 16'd1;
                            end
                        end else if (!cfg.full_drop && pitch < -lvl) begin
                            r.left_drv = '0;
                            r.right_drv = '0;
                            r.brake = BRAKE_HOLD;
                            r.finished = finish_crossing(BRAKE_HOLD);
                        end
                    end
                end
            end
        end else begin
            r.brake = last_stop;
        end
        r.phase = ph;
        r.index = done_cnt;
        return r;
    endfunction

    function automatic t_crossing_result res(int l, int r, logic [1:0] b, logic [2:0] p,
                                             int idx, logic fin);
        t_crossing_result x;
        x.left_drv = l[7:0];
        x.right_drv = r[7:0];
        x.brake = b;
        x.phase = p;
        x.index = idx[3:0];
        x.finished = fin;
        return x;
    endfunction

    function automatic t_crossing_cfg make_cfg(int cnt, int rev, int full, int climb, int lvl,
                                               int tmo, int gain, int land);
        t_crossing_cfg c;
        c.crossings = cnt[3:0];
        c.reverse_dir = rev[0];
        c.full_drop = full[0];
        c.climb_thr = climb[11:0];
        c.level_thr = lvl[11:0];
        c.timeout = tmo[15:0];
        c.gain = gain[9:0];
        c.landing = land[15:0];
        return c;
    endfunction

    task automatic add_row(int setup, logic act, int roll, int hdg, logic fixed_exp,
                           t_crossing_result want);
        t_stim_row row;
        row.setup = setup[3:0];
        row.act = act;
        row.roll = roll[12:0];
        row.hdg = hdg[12:0];
        row.fixed_exp = fixed_exp;
        row.want = want;
        directed_rows.push_back(row);
    endtask

    function automatic int spread(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // Pick a pitch that moves the crossing on from where the predictor stands
    function automatic logic signed [12:0] next_roll();
        int p, lvl, clb;
        lvl = int'(cfg.level_thr);
        clb = int'(cfg.climb_thr);
        if ($urandom_range(99) < 12) begin
            p = spread(-4096, 4095);
            return p[12:0];
        end
        if (ph == PH_CROSSING && !climbed) begin
            p = ($urandom_range(3) == 0) ? spread(-200, 200) : clb + 1 + spread(0, 300);
        end else if (ph == PH_CROSSING && !dropped) begin
            p = ($urandom_range(2) == 0) ? clb + 1 + spread(0, 300) : lvl - 1 - spread(0, 200);
        end else if (ph == PH_CROSSING) begin
            if ($urandom_range(3) == 0)
                p = spread(-600, 600);
            else if (cfg.full_drop)
                p = (lvl > 0) ? spread(-(lvl - 1), lvl - 1) : 0;
            else
                p = -lvl - 1 - spread(0, 200);
        end else begin
            p = spread(-200, 200);
        end
        if (p > 4095) p = 4095;
        if (p < -4095) p = -4095;
        if (cfg.reverse_dir) p = -p;
        return p[12:0];
    endfunction

    function automatic logic [12:0] next_heading();
        int pick, h;
        pick = $urandom_range(99);
        if (pick < 70)
            h = (int'(tgt_heading) + spread(-300, 300) + FULL_TURN) % FULL_TURN;
        else if (pick < 90)
            h = spread(0, FULL_TURN - 1);
        else
            h = spread(0, 8191);
        return h[12:0];
    endfunction

    task automatic send_item(logic act, logic signed [12:0] roll, logic [12:0] hdg,
                             logic fixed_exp, t_crossing_result want);
        t_crossing_result pred;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_roll_angle <= roll;
        i_heading_angle <= hdg;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pred = crossing_step(act, roll, hdg);
        results_due.push_back(fixed_exp ? want : pred);
        items_sent++;
        if (pred.finished) runs_ended++;
        if (pred.finished && pred.phase == PH_TIMED_OUT) timeouts_seen++;
    endtask

    // Hold the sender until every result is back, then let the pipeline settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(t_crossing_cfg s);
        drain_results();
        write_reg(CFG_CROSSING_COUNT, 16'(s.crossings));
        write_reg(CFG_REVERSE_DIR, 16'(s.reverse_dir));
        write_reg(CFG_FULL_DROP, 16'(s.full_drop));
        write_reg(CFG_CLIMB_THRESHOLD, 16'(s.climb_thr));
        write_reg(CFG_LEVEL_THRESHOLD, 16'(s.level_thr));
        write_reg(CFG_TIMEOUT_TICKS, s.timeout);
        write_reg(CFG_HEADING_GAIN, 16'(s.gain));
        write_reg(CFG_LANDING_TICKS, s.landing);
        i_cfg_we <= 1'b0;
        cfg = s;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_out_stall <= 1'b0;
        else
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_checked++;
            if (results_due.size() == 0) begin
                report_error($sformatf("result %0d arrived with nothing expected",
                                       results_checked));
            end else begin
                monitor_want = results_due.pop_front();
                if (o_left_drive !== monitor_want.left_drv)
                    report_error($sformatf("result %0d left_drive %0d, expected %0d",
                        results_checked, o_left_drive, monitor_want.left_drv));
                if (o_right_drive !== monitor_want.right_drv)
                    report_error($sformatf("result %0d right_drive %0d, expected %0d",
                        results_checked, o_right_drive, monitor_want.right_drv));
                if (o_brake_mode !== monitor_want.brake)
                    report_error($sformatf("result %0d brake_mode %0d, expected %0d",
                        results_checked, o_brake_mode, monitor_want.brake));
                if (o_phase !== monitor_want.phase)
                    report_error($sformatf("result %0d phase %0d, expected %0d",
                        results_checked, o_phase, monitor_want.phase));
                if (o_crossing_index !== monitor_want.index)
                    report_error($sformatf("result %0d crossing_index %0d, expected %0d",
                        results_checked, o_crossing_index, monitor_want.index));
                if (o_finished !== monitor_want.finished)
                    report_error($sformatf("result %0d finished %0d, expected %0d",
                        results_checked, o_finished, monitor_want.finished));
            end
        end
    end

    // Abort when neither channel has moved for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                     idle_cycles, results_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int cur_setup, useful, s;
        logic act;
        t_crossing_result cross0;

        settings[0] = make_cfg(2, 0, 1, 144, 8, 300, 112, 20);
        settings[1] = make_cfg(1, 0, 0, 0, 0, 3, 112, 0);
        settings[2] = make_cfg(0, 0, 0, 0, 0, 3, 112, 0);
        settings[3] = make_cfg(3, 0, 1, 144, 8, 300, 112, 5);
        settings[4] = make_cfg(15, 1, 0, 0, 0, 40, 1023, 0);
        settings[5] = make_cfg(1, 0, 1, 2880, 2880, 1, 0, 0);
        settings[6] = make_cfg(2, 0, 1, 2000, 600, 65535, 512, 65535);
        settings[7] = make_cfg(0, 0, 0, 4095, 4095, 8, 300, 3);
        settings[8] = make_cfg(4, 1, 1, 300, 100, 12, 700, 2);

        cfg = settings[0];
        ph = PH_IDLE;
        climbed = 1'b0;
        dropped = 1'b0;
        tgt_heading = '0;
        ticks = '0;
        done_cnt = '0;
        last_stop = BRAKE_NONE;

        cross0 = res(0, 0, BRAKE_NONE, PH_CROSSING, 0, 0);
        // Reset settings: idle tick, start, heading extremes, climb, crest, restart
        add_row(0, ACT_TICK, 0, 0, 1, res(0, 0, BRAKE_NONE, PH_IDLE, 0, 0));
        add_row(0, ACT_START, -4096, 0, 1, cross0);
        add_row(0, ACT_TICK, 0, 0, 1, res(127, 127, BRAKE_NONE, PH_CROSSING, 0, 0));
        add_row(0, ACT_TICK, 0, 2880, 1, res(-127, 127, BRAKE_NONE, PH_CROSSING, 0, 0));
        add_row(0, ACT_TICK, -4096, 8191, 0, '0);
        add_row(0, ACT_TICK, 4095, 5759, 0, '0);
        add_row(0, ACT_TICK, 0, 100, 0, '0);
        add_row(0, ACT_TICK, 100, 0, 0, '0);
        add_row(0, ACT_START, 0, 5759, 1, cross0);
        add_row(0, ACT_TICK, -2880, 5759, 0, '0);
        // Angled hold ends a single-crossing run, then a run that times out
        add_row(1, ACT_START, 2880, 0, 1, cross0);
        add_row(1, ACT_TICK, 1, 0, 0, '0);
        add_row(1, ACT_TICK, -1, 0, 1, res(0, 0, BRAKE_HOLD, PH_DONE, 1, 1));
        add_row(1, ACT_TICK, 0, 0, 1, res(0, 0, BRAKE_HOLD, PH_DONE, 1, 0));
        add_row(1, ACT_START, 0, 0, 1, cross0);
        repeat (4) add_row(1, ACT_TICK, 0, 0, 1, res(127, 127, BRAKE_NONE, PH_CROSSING, 0, 0));
        add_row(1, ACT_TICK, 0, 0, 1, res(0, 0, BRAKE_STOP, PH_TIMED_OUT, 0, 1));
        add_row(1, ACT_TICK, 0, 0, 1, res(0, 0, BRAKE_STOP, PH_TIMED_OUT, 0, 0));
        // Zero crossing count: the start alone ends the run
        add_row(2, ACT_START, 0, 0, 1, res(0, 0, BRAKE_NONE, PH_DONE, 0, 1));
        add_row(2, ACT_TICK, 0, 0, 1, res(0, 0, BRAKE_NONE, PH_DONE, 0, 0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cur_setup = 0;
        foreach (directed_rows[k]) begin
            if (directed_rows[k].setup != cur_setup) begin
                cur_setup = directed_rows[k].setup;
                apply_setting(settings[cur_setup]);
            end
            send_item(directed_rows[k].act, directed_rows[k].roll, directed_rows[k].hdg,
                      directed_rows[k].fixed_exp, directed_rows[k].want);
        end

        for (s = 3; s < 9; s++) begin
            unique case ((s - 3) / 2)
                0: begin
                    send_idle_pct = 15;
                    recv_idle_pct = 45;
                end
                1: begin
                    send_idle_pct = 45;
                    recv_idle_pct = 15;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            apply_setting(settings[s]);
            useful = 0;
            while (useful < PHASE_ITEMS) begin
                // Ticks in idle, done or timed out change nothing; prefer a restart there
                if (ph == PH_IDLE || ph == PH_DONE || ph == PH_TIMED_OUT)
                    act = ($urandom_range(99) < 60) ? ACT_START : ACT_TICK;
                else
                    act = ($urandom_range(99) < 3) ? ACT_START : ACT_TICK;
                if (act == ACT_START || !(ph == PH_IDLE || ph == PH_DONE || ph == PH_TIMED_OUT))
                    useful++;
                send_item(act, next_roll(), next_heading(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);

        $display("Sent %0d items over 9 register settings; %0d results checked.",
                 items_sent, results_checked);
        $display("Runs ended: %0d, of which %0d by timeout.", runs_ended, timeouts_seen);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/bcc_pkg.sv
design/bcc_drive.sv
design/barrier_crossing_controller_unit.sv
verif/testbench.sv
